/* src/alid_pkg.sv */
`timescale 1ns / 1ps

package alid_pkg;

    localparam int LIST_CAPACITY = 64;
    localparam int DATA_W        = 32;
    localparam int CNT_W         = 7;
    localparam int POS_W         = 7;
    localparam int FUNC_W        = 3;
    localparam int STATUS_W      = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR   = 3'd0,
        FN_LOAD    = 3'd1,
        FN_INSERT  = 3'd2,
        FN_DELETE  = 3'd3,
        FN_DISPLAY = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK     = 2'd0,
        STS_BADPOS = 2'd1,
        STS_FULL   = 2'd2,
        STS_EMPTY  = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_DISP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;
        logic rotate;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic disp_go;
        logic disp_last;
    } t_dp_stat;

endpackage

/* src/alid_ctrl.sv */
`timescale 1ns / 1ps

module alid_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  alid_pkg::t_dp_stat i_stat,
    output logic             o_in_stall,
    output alid_pkg::t_cmd   o_cmd
);
    import alid_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_stat.out_free && i_stat.disp_go) begin
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                if (i_stat.out_free && i_stat.disp_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b1;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = !i_stat.out_free;
                o_cmd.exec = i_in_valid && i_stat.out_free;
            end
            ST_DISP: begin
                o_cmd.rotate = i_stat.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

/* src/alid_dp.sv */
`timescale 1ns / 1ps

module alid_dp #(
    parameter int CAPACITY = alid_pkg::LIST_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  alid_pkg::t_cmd                      i_cmd,
    input  logic [alid_pkg::FUNC_W-1:0]         i_func,
    input  logic [alid_pkg::POS_W-1:0]          i_position,
    input  logic signed [alid_pkg::DATA_W-1:0]  i_value,
    input  logic                                i_first,
    input  logic                                i_out_stall,
    output alid_pkg::t_dp_stat                  o_stat,
    output logic                                o_out_valid,
    output logic signed [alid_pkg::DATA_W-1:0]  o_elem_value,
    output logic [alid_pkg::STATUS_W-1:0]       o_status,
    output logic [alid_pkg::CNT_W-1:0]          o_count,
    output logic                                o_last
);
    import alid_pkg::*;

    logic signed [DATA_W-1:0] r_cell [CAPACITY];
    logic [CNT_W-1:0]         r_len;
    logic [CNT_W-1:0]         n_len;
    logic [CNT_W-1:0]         r_left;
    logic [CNT_W-1:0]         n_left;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic signed [DATA_W-1:0] r_elem;
    logic [STATUS_W-1:0]      r_status;
    logic [CNT_W-1:0]         r_count;
    logic                     r_last;

    t_status                  w_sts;
    logic                     w_load_out;
    logic                     w_disp_go;
    logic                     w_do_load;
    logic                     w_do_ins;
    logic                     w_do_del;
    logic [CNT_W-1:0]         w_load_idx;
    logic [CNT_W:0]           w_len8;
    logic [CNT_W:0]           w_pos8;
    logic [CNT_W:0]           w_p0;
    logic                     w_full;

    assign w_len8    = {1'b0, r_len};
    assign w_pos8    = {1'b0, i_position};
    assign w_p0      = w_pos8 - (CNT_W+1)'(1);
    assign w_full    = r_len >= CNT_W'(CAPACITY);
    assign w_disp_go = (t_func'(i_func) == FN_DISPLAY) && (r_len != '0);
    assign w_load_idx = i_first ? '0 : r_len;

    always_comb begin
        w_sts     = STS_OK;
        w_do_load = 1'b0;
        w_do_ins  = 1'b0;
        w_do_del  = 1'b0;
        n_len     = r_len;
        case (t_func'(i_func))
            FN_CLEAR: begin
                n_len = '0;
            end
            FN_LOAD: begin
                if (i_first || !w_full) begin
                    w_do_load = 1'b1;
                    n_len     = w_load_idx + CNT_W'(1);
                end else begin
                    w_sts = STS_FULL;
                end
            end
            FN_INSERT: begin
                if (i_position == '0 || w_pos8 > w_len8 + (CNT_W+1)'(1)) begin
                    w_sts = STS_BADPOS;
                end else if (w_full) begin
                    w_sts = STS_FULL;
                end else begin
                    w_do_ins = 1'b1;
                    n_len    = r_len + CNT_W'(1);
                end
            end
            FN_DELETE: begin
                if (i_position == '0 || w_pos8 > w_len8) begin
                    w_sts = STS_BADPOS;
                end else begin
                    w_do_del = 1'b1;
                    n_len    = r_len - CNT_W'(1);
                end
            end
            FN_DISPLAY: begin
                if (r_len == '0) begin
                    w_sts = STS_EMPTY;
                end
            end
            default: begin
                w_sts = STS_OK;
            end
        endcase
    end

    for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
        localparam logic [CNT_W:0] J = (CNT_W+1)'(j);
        logic signed [DATA_W-1:0] w_up;
        logic signed [DATA_W-1:0] w_dn;
        logic signed [DATA_W-1:0] n_cell;

        if (j < CAPACITY - 1) begin : g_up
            assign w_up = r_cell[j+1];
        end else begin : g_up_end
            assign w_up = r_cell[j];
        end
        if (j > 0) begin : g_dn
            assign w_dn = r_cell[j-1];
        end else begin : g_dn_end
            assign w_dn = r_cell[j];
        end

        always_comb begin
            n_cell = r_cell[j];
            if (i_cmd.rotate) begin
                if (J + (CNT_W+1)'(1) < w_len8) begin
                    n_cell = w_up;
                end else if (J + (CNT_W+1)'(1) == w_len8) begin
                    n_cell = r_cell[0];
                end
            end else if (i_cmd.exec) begin
                if (w_do_load && J == {1'b0, w_load_idx}) begin
                    n_cell = i_value;
                end else if (w_do_ins) begin
                    if (J == w_p0) begin
                        n_cell = i_value;
                    end else if (J > w_p0 && J <= w_len8) begin
                        n_cell = w_dn;
                    end
                end else if (w_do_del) begin
                    if (J >= w_p0 && J + (CNT_W+1)'(1) < w_len8) begin
                        n_cell = w_up;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_cell[j] <= n_cell;
        end
    end

    assign w_load_out  = (i_cmd.exec && !w_disp_go) || i_cmd.rotate;
    assign n_out_valid = w_load_out ? 1'b1 : (r_out_valid && i_out_stall);

    always_comb begin
        n_left = r_left;
        if (i_cmd.exec && w_disp_go) begin
            n_left = r_len;
        end else if (i_cmd.rotate) begin
            n_left = r_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_left      <= n_left;
            if (i_cmd.exec) begin
                r_len <= n_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rotate) begin
            r_elem   <= r_cell[0];
            r_status <= STS_OK;
            r_count  <= r_len;
            r_last   <= (r_left == CNT_W'(1));
        end else if (i_cmd.exec && !w_disp_go) begin
            r_elem   <= '0;
            r_status <= w_sts;
            r_count  <= n_len;
            r_last   <= 1'b1;
        end
    end

    assign o_stat.out_free  = !r_out_valid || !i_out_stall;
    assign o_stat.disp_go   = w_disp_go;
    assign o_stat.disp_last = (r_left == CNT_W'(1));

    assign o_out_valid  = r_out_valid;
    assign o_elem_value = r_elem;
    assign o_status     = r_status;
    assign o_count      = r_count;
    assign o_last       = r_last;

endmodule

/* src/array_list_insert_delete.sv */
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit values kept in a row of registers. Each input
// beat carries one operation: clear, load (append, first restarts the list), insert before a
// 1-based position, delete at a position, or display. Clear, load, insert and delete update
// every cell at the accept edge, where each cell picks its neighbor, the new value or itself,
// and the single result beat is registered at that same edge. A display of a non-empty list
// streams one entry per cycle while the output is not stalled, as the list is rotated through
// cell zero once to stream the entries out; no new beat is taken until the final entry is
// loaded into the output register. A result that waits under stall holds off the next input
// beat, and a result that leaves at an edge lets a new beat in at that edge.
module array_list_insert_delete #(
    parameter int CAPACITY = alid_pkg::LIST_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [alid_pkg::FUNC_W-1:0]         i_func,
    input  logic [alid_pkg::POS_W-1:0]          i_position,
    input  logic signed [alid_pkg::DATA_W-1:0]  i_value,
    input  logic                                i_first,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [alid_pkg::DATA_W-1:0]  o_elem_value,
    output logic [alid_pkg::STATUS_W-1:0]       o_status,
    output logic [alid_pkg::CNT_W-1:0]          o_count,
    output logic                                o_last
);
    import alid_pkg::*;

    t_cmd     w_cmd;
    t_dp_stat w_stat;

    alid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    alid_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_func       (i_func),
        .i_position   (i_position),
        .i_value      (i_value),
        .i_first      (i_first),
        .i_out_stall  (i_out_stall),
        .o_stat       (w_stat),
        .o_out_valid  (o_out_valid),
        .o_elem_value (o_elem_value),
        .o_status     (o_status),
        .o_count      (o_count),
        .o_last       (o_last)
    );

endmodule

/* src/alid_checker.sv */
`timescale 1ns / 1ps

module alid_checker #(
    parameter int CAPACITY = alid_pkg::LIST_CAPACITY
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic [alid_pkg::FUNC_W-1:0]         i_func,
    input logic [alid_pkg::POS_W-1:0]          i_position,
    input logic signed [alid_pkg::DATA_W-1:0]  i_value,
    input logic                                i_first,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic signed [alid_pkg::DATA_W-1:0]  o_elem_value,
    input logic [alid_pkg::STATUS_W-1:0]       o_status,
    input logic [alid_pkg::CNT_W-1:0]          o_count,
    input logic                                o_last
);
    import alid_pkg::*;

    // A stalled output beat stays and keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_elem_value)
            && $stable(o_status) && $stable(o_count) && $stable(o_last))
        else $error("output beat changed while stalled");

    // A clear yields one final beat with an empty list.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_func == FN_CLEAR |=>
            o_out_valid && o_last && o_count == '0 && o_status == STS_OK)
        else $error("clear did not report an empty list");

    // Any error status comes on a single final beat with no element.
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != STS_OK |-> o_last && o_elem_value == '0)
        else $error("error status on a non-final or non-zero beat");

    // The reported length never exceeds the capacity.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_count <= CNT_W'(CAPACITY))
        else $error("list length above capacity");

    // No new beat is taken while a display is still streaming.
    a_disp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_in_stall)
        else $error("input taken during a display");

endmodule

bind array_list_insert_delete alid_checker #(.CAPACITY(CAPACITY)) u_alid_checker (.*);
